[design/hashed_allocation_tracker_defines.svh]
// Assertion macros for the hashed allocation tracker.
`ifndef HASHED_ALLOCATION_TRACKER_DEFINES_SVH
`define HASHED_ALLOCATION_TRACKER_DEFINES_SVH
`ifndef SYNTH
`define HAT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("lbl failed");
`define HAT_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lbl failed");
`else
`define HAT_ASSERT(lbl, clk, rstn, prop)
`define HAT_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[design/hat_pkg.sv]
// Package with shared types, constants and the hash constants.
package hat_pkg;
  localparam int unsigned TableDepthDefault = 4096;
  localparam int unsigned KeyW = 64;
  localparam int unsigned SizeW = 48;
  localparam int unsigned StatusW = 3;
  localparam int unsigned SlotOutW = 12;

  localparam logic [63:0] HashMul1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HashMul2 = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned HashShift = 33;
  localparam int unsigned BudgetDiv = 5;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNull      = 3'd1,
    StDuplicate = 3'd2,
    StFull      = 3'd3,
    StUntracked = 3'd4,
    StHardLimit = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SlotEmpty = 2'd0,
    SlotUsed  = 2'd1,
    SlotTomb  = 2'd2
  } slot_e;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;
    logic mul_step;
    logic budget_chk;
    logic probe_rd;
    logic probe_adv;
    logic commit_rec;
    logic commit_rel;
    logic clear_wr;
  } hat_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic key_zero;
    logic is_release;
    logic hard_limit;
    logic slot_free;
    logic slot_empty;
    logic key_match;
    logic scan_done;
    logic clear_done;
  } hat_stat_t;
endpackage

[design/hat_stream_if.sv]
// Valid/ready request channel interfaces.
interface hat_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] key;
  logic [47:0] size_bytes;
  modport source (output valid, opcode, key, size_bytes, input ready);
  modport sink (input valid, opcode, key, size_bytes, output ready);
endinterface

interface hat_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] slot_index;
  logic        warn_event;
  logic [47:0] total_bytes;
  modport source (output valid, status, slot_index, warn_event, total_bytes, input ready);
  modport sink (input valid, status, slot_index, warn_event, total_bytes, output ready);
endinterface

interface hat_cfg_if;
  logic        valid;
  logic        ready;
  logic [47:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[design/hashed_allocation_tracker.sv]
// Top level of the hashed allocation tracker.
// A request is taken in the idle state, then passes through the hash steps of the two split
// 64-bit hash multiplies, the budget check, a table read and a compare for each probed slot,
// and a last step that moves the result into the output register. A zero key skips the
// budget check and the probe; a refused record skips the probe. The output register lets
// the next request start while a result waits; a finished request holds in its last step
// until the previous result has been taken. After reset a clearing pass writes every slot
// status, one per cycle, before the first request is taken.
`include "hashed_allocation_tracker_defines.svh"
module hashed_allocation_tracker import hat_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hat_req_if.sink   req_i,
  hat_rsp_if.source rsp_o,
  hat_cfg_if.sink   cfg_i
);
  hat_cmd_t  cmd;
  hat_stat_t stat;
  logic [StatusW-1:0]  dp_status, ctl_status;
  logic [SlotOutW-1:0] dp_slot;
  logic [SizeW-1:0]    dp_total;
  logic dp_warn, slot_en, warn_en, rsp_valid, rsp_load;

  logic [StatusW-1:0]  rsp_status_q;
  logic [SlotOutW-1:0] rsp_slot_q;
  logic                rsp_warn_q;
  logic [SizeW-1:0]    rsp_total_q;

  assign cfg_i.ready = 1'b1;

  hat_datapath #(.TableDepth(TableDepth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .req_opcode_i(req_i.opcode), .req_key_i(req_i.key), .req_size_i(req_i.size_bytes),
    .cfg_we_i(cfg_i.valid), .cfg_data_i(cfg_i.data),
    .res_status_o(dp_status), .res_slot_o(dp_slot), .res_warn_o(dp_warn),
    .res_total_o(dp_total)
  );

  hat_controller u_ctl (
    .clk_i, .rst_ni, .req_valid_i(req_i.valid), .req_ready_o(req_i.ready),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_o.ready), .rsp_load_o(rsp_load),
    .rsp_status_o(ctl_status), .rsp_slot_en_o(slot_en), .rsp_warn_en_o(warn_en),
    .cmd_o(cmd), .stat_i(stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_status_q <= '0;
      rsp_slot_q   <= '0;
      rsp_warn_q   <= 1'b0;
      rsp_total_q  <= '0;
    end else if (rsp_load) begin
      rsp_status_q <= ctl_status | dp_status;
      rsp_slot_q   <= slot_en ? dp_slot : '0;
      rsp_warn_q   <= warn_en & dp_warn;
      rsp_total_q  <= dp_total;
    end
  end

  assign rsp_o.valid       = rsp_valid;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.slot_index  = rsp_slot_q;
  assign rsp_o.warn_event  = rsp_warn_q;
  assign rsp_o.total_bytes = rsp_total_q;

  `HAT_ASSERT(a_no_accept_while_busy, clk_i, rst_ni, rsp_valid && !rsp_o.ready |=> rsp_valid)
  `HAT_ASSERT(a_one_commit, clk_i, rst_ni, !(cmd.commit_rec && cmd.commit_rel))
  `HAT_ASSERT(a_no_clear_in_probe, clk_i, rst_ni, cmd.clear_wr |-> !req_i.ready)
endmodule

[design/hat_datapath.sv]
// Datapath: hash unit, slot tables, byte total and budget checks.
module hat_datapath import hat_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault,
  localparam int unsigned IdxW = $clog2(TableDepth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hat_cmd_t            cmd_i,
  output hat_stat_t           stat_o,
  input  logic                req_opcode_i,
  input  logic [KeyW-1:0]     req_key_i,
  input  logic [SizeW-1:0]    req_size_i,
  input  logic                cfg_we_i,
  input  logic [SizeW-1:0]    cfg_data_i,
  output logic [StatusW-1:0]  res_status_o,
  output logic [SlotOutW-1:0] res_slot_o,
  output logic                res_warn_o,
  output logic [SizeW-1:0]    res_total_o
);
  logic [1:0]       status_mem [TableDepth];
  logic [KeyW-1:0]  key_mem [TableDepth];
  logic [SizeW-1:0] size_mem [TableDepth];

  logic [SizeW-1:0] budget_q, total_q, total_d;
  logic [SizeW+3:0] limit_q, need5;
  logic             warned_q, warn_q;
  logic             op_q;
  logic [KeyW-1:0]  key_q, h_q;
  logic [SizeW-1:0] size_q;
  logic [SizeW:0]   need_q;
  logic [2:0]       mstep_q;
  logic [IdxW-1:0]  idx_q, clr_q;
  logic [IdxW:0]    cnt_q;
  logic [1:0]       rd_st_q;
  logic [KeyW-1:0]  rd_key_q;
  logic [SizeW-1:0] rd_size_q;
  logic             hard_q;

  // Hash: five steps, the 64-bit products split over two 32-bit halves.
  logic [63:0] mul_k, prod_lo, prod_cross, prod_cross2;
  logic [63:0] part_q;
  always_comb begin
    mul_k = (mstep_q < 3'd3) ? HashMul1 : HashMul2;
    prod_lo = {32'd0, h_q[31:0]} * {32'd0, mul_k[31:0]};
    prod_cross = {32'd0, h_q[63:32]} * {32'd0, mul_k[31:0]};
    prod_cross2 = {32'd0, h_q[31:0]} * {32'd0, mul_k[63:32]};
  end

  // The need is above budget plus a fifth of it exactly when five times the need
  // exceeds six times the budget.
  assign need5 = {1'b0, need_q, 2'b00} + {3'b000, need_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
      limit_q  <= '0;
      total_q  <= '0;
      warned_q <= 1'b0;
      mstep_q  <= '0;
      clr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        budget_q <= cfg_data_i;
        limit_q  <= {2'b00, cfg_data_i, 2'b00} + {3'b000, cfg_data_i, 1'b0};
      end
      if (cmd_i.clear_wr) clr_q <= clr_q + 1'b1;
      total_q <= total_d;
      if (cmd_i.budget_chk && !op_q && budget_q != '0 && need_q > {1'b0, budget_q}) begin
        warned_q <= 1'b1;
      end
      if (cmd_i.load) mstep_q <= '0;
      else if (cmd_i.mul_step) mstep_q <= mstep_q + 1'b1;
    end
  end

  always_comb begin
    total_d = total_q;
    if (cmd_i.commit_rec) total_d = need_q[SizeW] ? '1 : need_q[SizeW-1:0];
    else if (cmd_i.commit_rel) total_d = (total_q > rd_size_q) ? total_q - rd_size_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= req_opcode_i;
      key_q  <= req_key_i;
      size_q <= req_size_i;
      h_q    <= req_key_i ^ (req_key_i >> HashShift);
      warn_q <= 1'b0;
      hard_q <= 1'b0;
      need_q <= {1'b0, total_q} + {1'b0, req_size_i};
    end else if (cmd_i.mul_step) begin
      unique case (mstep_q)
        3'd0, 3'd3: part_q <= prod_lo;
        3'd1, 3'd4: h_q <= part_q + {prod_cross[31:0] + prod_cross2[31:0], 32'd0};
        3'd2: h_q <= h_q ^ (h_q >> HashShift);
        default: h_q <= h_q;
      endcase
    end
    if (cmd_i.budget_chk) begin
      if (budget_q != '0 && !op_q) begin
        warn_q <= (need_q > {1'b0, budget_q}) && !warned_q;
        hard_q <= need5 > limit_q;
      end
      idx_q <= IdxW'((h_q ^ (h_q >> HashShift)) & 64'hFFFF_FFFF);
      cnt_q <= '0;
    end
    if (cmd_i.probe_adv) begin
      idx_q <= idx_q + 1'b1;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_rd) begin
      rd_st_q   <= status_mem[idx_q];
      rd_key_q  <= key_mem[idx_q];
      rd_size_q <= size_mem[idx_q];
    end
    if (cmd_i.clear_wr) status_mem[clr_q] <= SlotEmpty;
    else if (cmd_i.commit_rec) status_mem[idx_q] <= SlotUsed;
    else if (cmd_i.commit_rel) status_mem[idx_q] <= SlotTomb;
    if (cmd_i.commit_rec) begin
      key_mem[idx_q]  <= key_q;
      size_mem[idx_q] <= size_q;
    end
  end

  always_comb begin
    stat_o.key_zero   = (key_q == '0);
    stat_o.is_release = op_q;
    stat_o.hard_limit = hard_q;
    stat_o.slot_free  = (rd_st_q != SlotUsed);
    stat_o.slot_empty = (rd_st_q == SlotEmpty);
    stat_o.key_match  = (rd_st_q == SlotUsed) && (rd_key_q == key_q);
    stat_o.scan_done  = (cnt_q == (IdxW+1)'(TableDepth - 1));
    stat_o.clear_done = (clr_q == IdxW'(TableDepth - 1));
  end

  assign res_warn_o  = warn_q;
  assign res_total_o = total_q;
  assign res_status_o = '0;
  assign res_slot_o  = SlotOutW'({{SlotOutW{1'b0}}, idx_q});
endmodule

[design/hat_controller.sv]
// Controller state machine sequencing hash, budget check and probing.
module hat_controller import hat_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output logic          rsp_load_o,
  output logic [2:0]    rsp_status_o,
  output logic          rsp_slot_en_o,
  output logic          rsp_warn_en_o,
  output hat_cmd_t      cmd_o,
  input  hat_stat_t     stat_i
);
  localparam logic [3:0] SClear = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SHash  = 4'd2;
  localparam logic [3:0] SBudg  = 4'd3;
  localparam logic [3:0] SRead  = 4'd4;
  localparam logic [3:0] SEval  = 4'd5;
  localparam logic [3:0] SDone  = 4'd6;
  localparam logic [3:0] SLast  = 4'd7;

  logic [3:0] state_q, state_d;
  logic [2:0] hcnt_q;
  logic [2:0] st_q, st_d;
  logic       slot_q, slot_d, wen_q, wen_d;
  logic       out_v_q;

  always_comb begin
    state_d = state_q;
    st_d = st_q;
    slot_d = slot_q;
    wen_d = wen_q;
    cmd_o = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      SClear: begin
        cmd_o.clear_wr = 1'b1;
        if (stat_i.clear_done) state_d = SIdle;
      end
      SIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = SHash;
        end
      end
      SHash: begin
        cmd_o.mul_step = 1'b1;
        if (hcnt_q == 3'd4) state_d = SBudg;
      end
      SBudg: begin
        slot_d = 1'b0;
        wen_d = 1'b0;
        if (stat_i.key_zero) begin
          st_d = StNull;
          state_d = SDone;
        end else begin
          cmd_o.budget_chk = 1'b1;
          state_d = SLast;
        end
      end
      SLast: begin
        wen_d = !stat_i.is_release;
        if (!stat_i.is_release && stat_i.hard_limit) begin
          st_d = StHardLimit;
          state_d = SDone;
        end else state_d = SRead;
      end
      SRead: begin
        cmd_o.probe_rd = 1'b1;
        state_d = SEval;
      end
      SEval: begin
        if (!stat_i.is_release) begin
          if (stat_i.slot_free) begin
            cmd_o.commit_rec = 1'b1;
            st_d = StOk;
            slot_d = 1'b1;
            state_d = SDone;
          end else if (stat_i.key_match) begin
            st_d = StDuplicate;
            state_d = SDone;
          end else if (stat_i.scan_done) begin
            st_d = StFull;
            state_d = SDone;
          end else begin
            cmd_o.probe_adv = 1'b1;
            state_d = SRead;
          end
        end else begin
          if (stat_i.slot_empty) begin
            st_d = StUntracked;
            state_d = SDone;
          end else if (stat_i.key_match) begin
            cmd_o.commit_rel = 1'b1;
            st_d = StOk;
            slot_d = 1'b1;
            state_d = SDone;
          end else if (stat_i.scan_done) begin
            st_d = StUntracked;
            state_d = SDone;
          end else begin
            cmd_o.probe_adv = 1'b1;
            state_d = SRead;
          end
        end
      end
      SDone: begin
        if (!out_v_q || rsp_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  assign rsp_load_o = (state_q == SDone) && (state_d == SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      hcnt_q <= '0;
      st_q <= '0;
      slot_q <= 1'b0;
      wen_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q <= st_d;
      slot_q <= slot_d;
      wen_q <= wen_d;
      hcnt_q <= (state_q == SHash) ? hcnt_q + 1'b1 : '0;
      if (rsp_load_o) out_v_q <= 1'b1;
      else if (rsp_ready_i) out_v_q <= 1'b0;
    end
  end

  // The output register is loaded on leaving SDone, which waits while the previous result is held.
  assign rsp_valid_o = out_v_q;
  assign rsp_status_o = st_q;
  assign rsp_slot_en_o = slot_q;
  assign rsp_warn_en_o = wen_q;
endmodule

[test/tb.sv]
// Self-checking testbench for the hashed allocation tracker: directed and random requests.
module tb;
  import hat_pkg::*;

  typedef struct {
    logic        opcode;
    logic [63:0] key;
    logic [47:0] size_bytes;
  } alloc_req_t;

  typedef struct {
    status_e     status;
    logic [11:0] slot_index;
    logic        warn_event;
    logic [47:0] total_bytes;
  } alloc_rsp_t;

  localparam int unsigned Depth = 4096;
  localparam logic OpRecord = 1'b0;
  localparam logic OpRelease = 1'b1;
  localparam logic [47:0] SizeMax = 48'hffff_ffff_ffff;
  localparam int unsigned StallLimit = 60000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hat_req_if req_if ();
  hat_rsp_if rsp_if ();
  hat_cfg_if cfg_if ();

  hashed_allocation_tracker uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source),
    .cfg_i (cfg_if.sink)
  );

  always #6 clk_i = ~clk_i;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  logic [63:0] live_keys[$];

  slot_e       tbl_state[Depth];
  logic [63:0] tbl_key[Depth];
  logic [47:0] tbl_size[Depth];
  logic [47:0] bytes_held;
  logic        warned;
  logic [47:0] budget;
  int unsigned slots_used;

  int unsigned errors;
  int unsigned rsp_count;
  int unsigned status_seen[6];
  int unsigned stall_cycles;
  bit          burst;
  int unsigned send_gap;
  int unsigned recv_stall;

  function automatic logic [11:0] home_of(logic [63:0] k);
    logic [63:0] h;
    h = k;
    h = h ^ (h >> 33);
    h = h * 64'hff51afd7ed558ccd;
    h = h ^ (h >> 33);
    h = h * 64'hc4ceb9fe1a85ec53;
    h = h ^ (h >> 33);
    return h[11:0];
  endfunction

  function automatic alloc_rsp_t track_alloc(alloc_req_t r);
    alloc_rsp_t  res;
    logic [49:0] need;
    logic [49:0] hard;
    logic [11:0] idx;
    int unsigned n;
    res.status = StOk;
    res.slot_index = '0;
    res.warn_event = 1'b0;
    if (r.key == '0) begin
      res.status = StNull;
      res.total_bytes = bytes_held;
      return res;
    end
    idx = home_of(r.key);
    if (r.opcode == OpRecord) begin
      if (budget != '0) begin
        need = {2'b0, bytes_held} + {2'b0, r.size_bytes};
        hard = {2'b0, budget} + {2'b0, budget / 5};
        if (need > {2'b0, budget} && !warned) begin
          warned = 1'b1;
          res.warn_event = 1'b1;
        end
        if (need > hard) begin
          res.status = StHardLimit;
          res.total_bytes = bytes_held;
          return res;
        end
      end
      res.status = StFull;
      for (n = 0; n < Depth; n++) begin
        if (tbl_state[idx] != SlotUsed) begin
          tbl_state[idx] = SlotUsed;
          tbl_key[idx] = r.key;
          tbl_size[idx] = r.size_bytes;
          slots_used++;
          need = {2'b0, bytes_held} + {2'b0, r.size_bytes};
          bytes_held = need > {2'b0, SizeMax} ? SizeMax : need[47:0];
          res.status = StOk;
          res.slot_index = idx;
          break;
        end
        if (tbl_key[idx] == r.key) begin
          res.status = StDuplicate;
          break;
        end
        idx = idx + 1'b1;
      end
    end else begin
      res.status = StUntracked;
      for (n = 0; n < Depth; n++) begin
        if (tbl_state[idx] == SlotEmpty) break;
        if (tbl_state[idx] == SlotUsed && tbl_key[idx] == r.key) begin
          tbl_state[idx] = SlotTomb;
          slots_used--;
          bytes_held = bytes_held > tbl_size[idx] ? bytes_held - tbl_size[idx] : '0;
          res.status = StOk;
          res.slot_index = idx;
          break;
        end
        idx = idx + 1'b1;
      end
    end
    res.total_bytes = bytes_held;
    return res;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch on response %0d: %s got %0h expected %0h", rsp_count, field, got, want);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_req_t r;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (send_gap != 0) begin
        req_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        req_if.valid <= 1'b1;
        req_if.opcode <= r.opcode;
        req_if.key <= r.key;
        req_if.size_bytes <= r.size_bytes;
        send_gap <= burst ? 0 : $urandom_range(0, 7);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response stall generator.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned d;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      recv_stall <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      d = burst ? 0 : $urandom_range(0, 7);
      recv_stall <= d;
      rsp_if.ready <= (d == 0);
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      rsp_if.ready <= (recv_stall == 1);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) burst <= ~burst;
  end

  // Monitor, checker and watchdog.
  always @(posedge clk_i) begin
    alloc_req_t r;
    alloc_rsp_t want;
    bit         moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        rsp_count++;
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("response %0d arrived with no request outstanding", rsp_count);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.status <= 3'd5) status_seen[rsp_if.status]++;
          if (rsp_if.status !== want.status)
            report("status", 64'(rsp_if.status), 64'(want.status));
          if (rsp_if.slot_index !== want.slot_index)
            report("slot_index", 64'(rsp_if.slot_index), 64'(want.slot_index));
          if (rsp_if.warn_event !== want.warn_event)
            report("warn_event", 64'(rsp_if.warn_event), 64'(want.warn_event));
          if (rsp_if.total_bytes !== want.total_bytes)
            report("total_bytes", 64'(rsp_if.total_bytes), 64'(want.total_bytes));
        end
      end
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        r.opcode = req_if.opcode;
        r.key = req_if.key;
        r.size_bytes = req_if.size_bytes;
        expected_rsps.push_back(track_alloc(r));
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        budget <= cfg_if.data;
      end
      if (moved) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send(logic op, logic [63:0] k, logic [47:0] sz);
    alloc_req_t r;
    r.opcode = op;
    r.key = k;
    r.size_bytes = sz;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    do begin
      @(negedge clk_i);
    end while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_budget(logic [47:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    if (k == '0) k = 64'h1;
    return k;
  endfunction

  function automatic logic [47:0] rand_size(bit wide, int unsigned small_max);
    if (wide && $urandom_range(0, 3) == 0) return 48'({$urandom, $urandom});
    return 48'($urandom_range(0, small_max));
  endfunction

  task automatic random_mix(int unsigned count, bit wide, int unsigned small_max);
    int unsigned pick;
    int unsigned j;
    logic [63:0] k;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send(1'($urandom_range(0, 1)), '0, rand_size(1, small_max));
      end else if (pick < 15 && live_keys.size() != 0) begin
        send(OpRecord, live_keys[$urandom_range(0, live_keys.size() - 1)],
             rand_size(wide, small_max));
      end else if (pick < 50 && live_keys.size() != 0) begin
        j = $urandom_range(0, live_keys.size() - 1);
        send(OpRelease, live_keys[j], rand_size(1, small_max));
        live_keys.delete(j);
      end else if (pick < 58) begin
        send(OpRelease, rand_key(), rand_size(1, small_max));
      end else begin
        k = rand_key();
        live_keys.push_back(k);
        send(OpRecord, k, rand_size(wide, small_max));
      end
    end
  endtask

  initial begin
    logic [63:0] k;
    errors = 0;
    rsp_count = 0;
    stall_cycles = 0;
    burst = 1'b0;
    bytes_held = '0;
    warned = 1'b0;
    budget = '0;
    slots_used = 0;
    for (int i = 0; i < Depth; i++) tbl_state[i] = SlotEmpty;
    req_if.valid = 1'b0;
    req_if.opcode = 1'b0;
    req_if.key = '0;
    req_if.size_bytes = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Null keys, duplicates, untracked releases and saturation with no budget.
    send(OpRecord, '0, SizeMax);
    send(OpRelease, '0, '0);
    send(OpRecord, 64'h1, '0);
    send(OpRecord, 64'h1, 48'd7);
    send(OpRelease, 64'h1, '0);
    send(OpRelease, 64'h1, '0);
    send(OpRecord, 64'h1, 48'd9);
    send(OpRelease, 64'h8000_0000_0000_0000, SizeMax);
    send(OpRecord, 64'hffff_ffff_ffff_ffff, SizeMax);
    send(OpRecord, 64'h8000_0000_0000_0000, 48'd10);
    send(OpRelease, 64'hffff_ffff_ffff_ffff, '0);
    send(OpRelease, 64'h8000_0000_0000_0000, '0);
    send(OpRelease, 64'h1, '0);
    send(OpRelease, 64'h1234_5678_9abc_def0, '0);

    // Warning threshold, then the hard limit above budget plus one fifth.
    write_budget(48'd1000);
    send(OpRecord, 64'h10, 48'd1000);
    send(OpRecord, 64'h11, 48'd1);
    send(OpRecord, 64'h12, 48'd200);
    send(OpRecord, 64'h13, 48'd199);
    send(OpRecord, 64'h14, 48'd1);
    send(OpRelease, 64'h10, '0);
    send(OpRelease, 64'h11, '0);
    send(OpRelease, 64'h13, '0);
    random_mix(400, 0, 300);

    write_budget(SizeMax);
    random_mix(300, 1, 1 << 20);
    write_budget(48'd1);
    random_mix(200, 0, 2);
    write_budget('0);
    random_mix(600, 1, 1 << 16);

    // Records and releases of a key that is already in the table.
    drain();
    k = 64'h1;
    send(OpRecord, rand_key(), 48'd5);
    send(OpRelease, rand_key(), '0);
    for (int i = 0; i < Depth; i++) begin
      if (tbl_state[i] == SlotUsed) begin
        k = tbl_key[i];
        break;
      end
    end
    send(OpRecord, k, 48'd5);
    send(OpRelease, k, '0);
    send(OpRelease, k, '0);
    send(OpRecord, rand_key(), 48'd3);
    send(OpRecord, rand_key(), 48'd3);
    drain();

    $display("Checked %0d responses over budgets of zero, 1000, one and the maximum.",
             rsp_count);
    $display("Statuses seen: ok %0d, null %0d, dup %0d, full %0d, untracked %0d, limit %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    $display("Slots in use at the end: %0d.", slots_used);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/hat_pkg.sv
design/hat_stream_if.sv
design/hat_datapath.sv
design/hat_controller.sv
design/hashed_allocation_tracker.sv
test/tb.sv
